### rtl/core/two_level_bound_delay_lookup_assert.svh
// Assertion macros used by the delay lookup RTL.
`ifndef TWO_LEVEL_BOUND_DELAY_LOOKUP_ASSERT_SVH
`define TWO_LEVEL_BOUND_DELAY_LOOKUP_ASSERT_SVH
`ifndef SYNTH
`define TLB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TLB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TLB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TLB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/tlbdl_pkg.sv
// Shared types and constants of the two-level bound delay lookup.
package tlbdl_pkg;
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NEG  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_DUP  = 2'd3;

	localparam logic [1:0] SEQ_EXACT = 2'd0;
	localparam logic [1:0] SEQ_GE    = 2'd1;
	localparam logic [1:0] SEQ_GT    = 2'd2;

	localparam logic [1:0] CFG_DEFAULT_DELAY = 2'd0;
	localparam logic [1:0] CFG_SEQ_MODE      = 2'd1;
	localparam logic [1:0] CFG_CALC_MODE     = 2'd2;

	localparam logic [30:0] DEFAULT_DELAY_RST = 31'd800000;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// A classified request as queued between front and back.
	typedef struct packed {
		logic        lookup;
		logic        neg;
		logic [31:0] seq;
		logic [31:0] calc;
		logic [30:0] delay;
	} req_t;

	typedef struct packed {
		logic [30:0] delay_ns;
		logic        found;
		logic [1:0]  status;
	} rsp_t;
endpackage

### rtl/core/tlbdl_ram.sv
// Generic single-port RAM with registered read.
module tlbdl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

### rtl/core/tlbdl_front.sv
// Front end: accepts request words, classifies them and queues them.
module tlbdl_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic signed [31:0] seq_no,
	input  logic signed [31:0] calc_offset,
	input  logic signed [31:0] delay_offset,
	output logic               q_valid,
	output tlbdl_pkg::req_t    q_data,
	input  logic               q_pop
);
	// Two-entry queue.
	tlbdl_pkg::req_t buf_q [2];
	logic            rd_q, wr_q;
	logic [1:0]      cnt_q;
	tlbdl_pkg::req_t cls;
	logic            push;

	always_comb begin
		cls.lookup = (req_type == tlbdl_pkg::REQ_LOOKUP);
		cls.neg    = calc_offset[31] | delay_offset[31];
		cls.seq    = seq_no;
		cls.calc   = calc_offset;
		cls.delay  = delay_offset[30:0];
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid & ~in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

### rtl/core/tlbdl_back.sv
// Back end: binary searches and sorted inserts over the entry memory.
`include "two_level_bound_delay_lookup_assert.svh"
module tlbdl_back #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  tlbdl_pkg::req_t q_data,
	output logic            q_pop,
	input  logic [30:0]     miss_delay,
	input  logic [1:0]      group_sel,
	input  logic            offset_sel,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [30:0]     delay_ns,
	output logic            found,
	output logic [1:0]      status
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = 32 + 31 + 31;

	typedef enum logic [3:0] {
		S_IDLE, S_SRCH, S_CMP, S_FETCH, S_USE, S_SHRD, S_SHWR, S_PUT, S_OUT
	} state_t;

	// What the running search or single read is for.
	typedef enum logic [3:0] {
		P_G0, P_G1, P_POS, P_DUP, P_LB, P_GT, P_GKEY, P_END, P_CPOS, P_HIT
	} phase_t;

	state_t             state_q;
	phase_t             ph_q;
	tlbdl_pkg::req_t    req_q;
	logic [CW-1:0]      cnt_q, lo_q, hi_q, g0_q, g1_q, pos_q, sh_q;
	logic signed [31:0] key_q;
	logic               strict_q, col_q;
	logic [AW-1:0]      addr;
	logic               we;
	logic [EW-1:0]      wdata, rdata;
	logic [CW-1:0]      mid;
	logic signed [31:0] rkey;
	logic               below;
	logic               full;

	tlbdl_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign mid   = lo_q + ((hi_q - lo_q) >> 1);
	assign rkey  = col_q ? $signed({1'b0, rdata[61:31]}) : $signed(rdata[93:62]);
	assign below = strict_q ? (rkey <= key_q) : (rkey < key_q);
	assign full  = (cnt_q == CW'(TABLE_DEPTH));
	assign q_pop = (state_q == S_IDLE) && q_valid;

	always_comb begin
		we    = 1'b0;
		addr  = mid[AW-1:0];
		wdata = rdata;
		unique case (state_q)
			S_FETCH: addr = pos_q[AW-1:0];
			S_SHRD:  addr = AW'(sh_q - CW'(1));
			S_SHWR: begin
				we   = 1'b1;
				addr = sh_q[AW-1:0];
			end
			S_PUT: begin
				we    = 1'b1;
				addr  = pos_q[AW-1:0];
				wdata = {req_q.seq, req_q.calc[30:0], req_q.delay};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ph_q      <= P_G0;
			req_q     <= '0;
			cnt_q     <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			g0_q      <= '0;
			g1_q      <= '0;
			pos_q     <= '0;
			sh_q      <= '0;
			key_q     <= '0;
			strict_q  <= 1'b0;
			col_q     <= 1'b0;
			out_valid <= 1'b0;
			delay_ns  <= '0;
			found     <= 1'b0;
			status    <= tlbdl_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						req_q    <= q_data;
						lo_q     <= '0;
						hi_q     <= cnt_q;
						key_q    <= q_data.seq;
						col_q    <= 1'b0;
						strict_q <= 1'b0;
						delay_ns <= '0;
						found    <= 1'b0;
						status   <= tlbdl_pkg::ST_OK;
						if (!q_data.lookup && q_data.neg) begin
							status  <= tlbdl_pkg::ST_NEG;
							state_q <= S_OUT;
						end else begin
							ph_q    <= q_data.lookup ? P_LB : P_G0;
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						state_q <= S_CMP;
					end else begin
						// The search has closed on lo_q.
						unique case (ph_q)
							P_G0: begin
								g0_q     <= lo_q;
								hi_q     <= cnt_q;
								strict_q <= 1'b1;
								ph_q     <= P_G1;
							end
							P_G1: begin
								g1_q     <= lo_q;
								hi_q     <= lo_q;
								lo_q     <= g0_q;
								key_q    <= req_q.calc;
								col_q    <= 1'b1;
								strict_q <= 1'b0;
								ph_q     <= P_POS;
							end
							P_POS: begin
								pos_q <= lo_q;
								if (lo_q < g1_q) begin
									ph_q    <= P_DUP;
									state_q <= S_FETCH;
								end else if (full) begin
									status  <= tlbdl_pkg::ST_FULL;
									state_q <= S_OUT;
								end else begin
									sh_q    <= cnt_q;
									state_q <= (cnt_q > lo_q) ? S_SHRD : S_PUT;
								end
							end
							P_LB: begin
								unique case (group_sel)
									tlbdl_pkg::SEQ_EXACT, tlbdl_pkg::SEQ_GE: begin
										if (lo_q >= cnt_q) begin
											delay_ns <= miss_delay;
											state_q  <= S_OUT;
										end else begin
											pos_q   <= lo_q;
											ph_q    <= P_GKEY;
											state_q <= S_FETCH;
										end
									end
									tlbdl_pkg::SEQ_GT: begin
										hi_q     <= cnt_q;
										strict_q <= 1'b1;
										ph_q     <= P_GT;
									end
									default: begin
										delay_ns <= miss_delay;
										state_q  <= S_OUT;
									end
								endcase
							end
							P_GT: begin
								if (lo_q >= cnt_q) begin
									delay_ns <= miss_delay;
									state_q  <= S_OUT;
								end else begin
									pos_q   <= lo_q;
									ph_q    <= P_GKEY;
									state_q <= S_FETCH;
								end
							end
							P_END: begin
								g1_q     <= lo_q;
								hi_q     <= lo_q;
								lo_q     <= g0_q;
								key_q    <= req_q.calc;
								col_q    <= 1'b1;
								strict_q <= offset_sel;
								ph_q     <= P_CPOS;
							end
							P_CPOS: begin
								if (lo_q >= g1_q) begin
									delay_ns <= miss_delay;
									state_q  <= S_OUT;
								end else begin
									pos_q   <= lo_q;
									ph_q    <= P_HIT;
									state_q <= S_FETCH;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_CMP: begin
					if (below) begin
						lo_q <= mid + CW'(1);
					end else begin
						hi_q <= mid;
					end
					state_q <= S_SRCH;
				end
				S_FETCH: state_q <= S_USE;
				S_USE: begin
					unique case (ph_q)
						P_DUP: begin
							if (rdata[61:31] == req_q.calc[30:0]) begin
								status  <= tlbdl_pkg::ST_DUP;
								state_q <= S_OUT;
							end else if (full) begin
								status  <= tlbdl_pkg::ST_FULL;
								state_q <= S_OUT;
							end else begin
								sh_q    <= cnt_q;
								state_q <= (cnt_q > pos_q) ? S_SHRD : S_PUT;
							end
						end
						P_GKEY: begin
							if (group_sel == tlbdl_pkg::SEQ_EXACT
									&& rdata[93:62] != req_q.seq) begin
								delay_ns <= miss_delay;
								state_q  <= S_OUT;
							end else begin
								g0_q     <= pos_q;
								lo_q     <= pos_q;
								hi_q     <= cnt_q;
								key_q    <= rdata[93:62];
								col_q    <= 1'b0;
								strict_q <= 1'b1;
								ph_q     <= P_END;
								state_q  <= S_SRCH;
							end
						end
						P_HIT: begin
							delay_ns <= rdata[30:0];
							found    <= 1'b1;
							state_q  <= S_OUT;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					sh_q    <= sh_q - CW'(1);
					state_q <= (sh_q - CW'(1) > pos_q) ? S_SHRD : S_PUT;
				end
				S_PUT: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TLB_ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CW'(TABLE_DEPTH))
	`TLB_ASSERT_IMPL(a_pop_idle, clk, arst_n, q_pop, !out_valid)
	`TLB_ASSERT_NEXT(a_put_grow, clk, arst_n, state_q == S_PUT, cnt_q == $past(cnt_q) + CW'(1))
	`TLB_ASSERT_IMPL(a_found_zero, clk, arst_n, out_valid && !found, status != tlbdl_pkg::ST_OK || req_q.lookup || delay_ns == '0)
	`TLB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(delay_ns) && $stable(found) && $stable(status))
endmodule

### rtl/core/two_level_bound_delay_lookup.sv
// Top level of the two-level sorted delay table with bound search.
// Requests are words on a valid/stall channel: inserts place an entry at its sorted
// (sequence, offset) place, lookups choose a sequence group and then an offset and
// return that entry's delay or the default delay. Exactly one result word follows
// each request, in order. A front queue of two words takes requests while the back
// end works on one at a time. Every search step is one memory read and one compare,
// and a search over n entries closes after about log2(n+1) steps. A lookup runs up
// to four searches and two single reads before its result word can be taken; an
// insert runs three searches and at most one read, then reads and writes back every
// entry that moves up to make room, and then writes the new entry. An insert with a
// negative field goes straight to its result word without a search. A stalled
// result word holds the back end. The single port of the entry memory serialises
// all these reads and writes. No clearing pass is needed after reset, since
// searches never read past the entry count.
module two_level_bound_delay_lookup #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic signed [31:0] seq_no,
	input  logic signed [31:0] calc_offset,
	input  logic signed [31:0] delay_offset,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [30:0]        delay_ns,
	output logic               found,
	output logic [1:0]         status,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data
);
	logic [30:0]     default_delay_q;
	logic [1:0]      seq_mode_q;
	logic            calc_mode_q;
	logic            q_valid, q_pop;
	tlbdl_pkg::req_t q_data;

	// Configuration registers; the user must change them only while the block is idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_delay_q <= tlbdl_pkg::DEFAULT_DELAY_RST;
			seq_mode_q      <= tlbdl_pkg::SEQ_EXACT;
			calc_mode_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tlbdl_pkg::CFG_DEFAULT_DELAY: default_delay_q <= cfg_data;
				tlbdl_pkg::CFG_SEQ_MODE:      seq_mode_q <= cfg_data[1:0];
				tlbdl_pkg::CFG_CALC_MODE:     calc_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tlbdl_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .seq_no(seq_no), .calc_offset(calc_offset),
		.delay_offset(delay_offset), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
	);

	tlbdl_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
		.miss_delay(default_delay_q), .group_sel(seq_mode_q), .offset_sel(calc_mode_q),
		.out_valid(out_valid), .out_stall(out_stall), .delay_ns(delay_ns),
		.found(found), .status(status)
	);
endmodule

### verif/testbench.sv
// Self-checking testbench for the two-level bound delay lookup block.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 1024;
	// Sequence mode code that selects no group at all.
	localparam logic [1:0] SEQ_NONE = 2'd3;
	// Longest insert moves every entry; stalls and gaps come on top.
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int SETTLE_CYCLES = 120;

	typedef struct {
		logic        req_type;
		logic [31:0] seq;
		logic [31:0] calc;
		logic [31:0] delay;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = tlbdl_pkg::REQ_INSERT;
	logic signed [31:0] seq_no = '0;
	logic signed [31:0] calc_offset = '0;
	logic signed [31:0] delay_offset = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [30:0] delay_ns;
	logic found;
	logic [1:0] status;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = tlbdl_pkg::CFG_DEFAULT_DELAY;
	logic [30:0] cfg_data = '0;

	two_level_bound_delay_lookup #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .seq_no(seq_no), .calc_offset(calc_offset),
		.delay_offset(delay_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.delay_ns(delay_ns), .found(found), .status(status),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Shadow copy of the sorted table and of the registers.
	longint      shadow_seq [TABLE_DEPTH];
	longint      shadow_calc [TABLE_DEPTH];
	logic [30:0] shadow_delay [TABLE_DEPTH];
	int unsigned shadow_count = 0;
	logic [30:0] cur_default = tlbdl_pkg::DEFAULT_DELAY_RST;
	logic [1:0]  cur_seq_mode = tlbdl_pkg::SEQ_EXACT;
	logic        cur_calc_mode = 1'b0;

	request_t           pending_reqs [$];
	tlbdl_pkg::rsp_t    expected_rsps [$];
	int                 error_count = 0;
	bit                 hold_sender = 1'b0;

	// First index in [lo, hi] whose key is at or above q, or above q when strict; hi when none.
	// The search runs over the calc column when on_calc is set.
	function automatic int unsigned key_bound(bit on_calc, int unsigned lo, int unsigned hi,
			longint q, bit strict);
		int unsigned mid;
		longint k;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			k = on_calc ? shadow_calc[mid] : shadow_seq[mid];
			if (strict ? (k <= q) : (k < q)) lo = mid + 1;
			else hi = mid;
		end
		return lo;
	endfunction

	// Apply one accepted request to the shadow table and return its response.
	function automatic tlbdl_pkg::rsp_t predict_response(request_t r);
		tlbdl_pkg::rsp_t rsp;
		longint s, c, d, gkey;
		int unsigned g0, g1, pos, start, stop, lb;
		bit hit;
		s = longint'(signed'(r.seq));
		c = longint'(signed'(r.calc));
		d = longint'(signed'(r.delay));
		rsp.delay_ns = '0;
		rsp.found = 1'b0;
		rsp.status = tlbdl_pkg::ST_OK;
		if (r.req_type == tlbdl_pkg::REQ_INSERT) begin
			if (c < 0 || d < 0) begin
				rsp.status = tlbdl_pkg::ST_NEG;
				return rsp;
			end
			g0 = key_bound(1'b0, 0, shadow_count, s, 1'b0);
			g1 = key_bound(1'b0, g0, shadow_count, s, 1'b1);
			pos = key_bound(1'b1, g0, g1, c, 1'b0);
			// A repeated key is reported even when the table is full.
			if (pos < g1 && shadow_calc[pos] == c) begin
				rsp.status = tlbdl_pkg::ST_DUP;
				return rsp;
			end
			if (shadow_count >= TABLE_DEPTH) begin
				rsp.status = tlbdl_pkg::ST_FULL;
				return rsp;
			end
			for (int unsigned i = shadow_count; i > pos; i--) begin
				shadow_seq[i] = shadow_seq[i-1];
				shadow_calc[i] = shadow_calc[i-1];
				shadow_delay[i] = shadow_delay[i-1];
			end
			shadow_seq[pos] = s;
			shadow_calc[pos] = c;
			shadow_delay[pos] = r.delay[30:0];
			shadow_count++;
			return rsp;
		end
		hit = 1'b0;
		lb = key_bound(1'b0, 0, shadow_count, s, 1'b0);
		start = shadow_count;
		case (cur_seq_mode)
			tlbdl_pkg::SEQ_EXACT: if (lb < shadow_count && shadow_seq[lb] == s) start = lb;
			tlbdl_pkg::SEQ_GE:    start = lb;
			tlbdl_pkg::SEQ_GT:    start = key_bound(1'b0, lb, shadow_count, s, 1'b1);
			default:              start = shadow_count;
		endcase
		if (start < shadow_count) begin
			gkey = shadow_seq[start];
			stop = key_bound(1'b0, start, shadow_count, gkey, 1'b1);
			pos = key_bound(1'b1, start, stop, c, cur_calc_mode);
			if (pos < stop) begin
				hit = 1'b1;
				rsp.delay_ns = shadow_delay[pos];
			end
		end
		rsp.found = hit;
		if (!hit) rsp.delay_ns = cur_default;
		return rsp;
	endfunction

	// Driver: presents queued request words in bursts separated by random gaps.
	int burst_left = 4;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_rsps.push_back(predict_response(pending_reqs[0]));
				void'(pending_reqs.pop_front());
			end
			// A stalled word stays on the bus unchanged.
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0 && !hold_sender) begin
					req_type <= pending_reqs[0].req_type;
					seq_no <= pending_reqs[0].seq;
					calc_offset <= pending_reqs[0].calc;
					delay_offset <= pending_reqs[0].delay;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						// Some bursts run back to back with no gap.
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stalls on its own pattern and checks every accepted result word.
	int stall_style = 0;
	int stall_span = 0;
	tlbdl_pkg::rsp_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_span == 0) begin
				stall_style <= $urandom_range(0, 3);
				stall_span <= $urandom_range(10, 300);
			end else begin
				stall_span <= stall_span - 1;
			end
			case (stall_style)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 9) < 3);
				2: out_stall <= ($urandom_range(0, 9) < 8);
				default: out_stall <= ($urandom_range(0, 1) == 0);
			endcase
			if (out_valid && !out_stall) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected result word delay_ns=%0d found=%0d status=%0d",
						$realtime, delay_ns, found, status);
					error_count++;
				end else begin
					want = expected_rsps.pop_front();
					if (delay_ns !== want.delay_ns) begin
						$display("%0t: delay_ns expected %0d actual %0d",
							$realtime, want.delay_ns, delay_ns);
						error_count++;
					end
					if (found !== want.found) begin
						$display("%0t: found expected %0d actual %0d",
							$realtime, want.found, found);
						error_count++;
					end
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$realtime, want.status, status);
						error_count++;
					end
				end
			end
		end
	end

	// Watchdog: only counts while work is outstanding.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (pending_reqs.size() == 0 && expected_rsps.size() == 0)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_req(logic kind, logic [31:0] s, logic [31:0] c, logic [31:0] d);
		request_t r;
		r.req_type = kind;
		r.seq = s;
		r.calc = c;
		r.delay = d;
		pending_reqs.push_back(r);
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; the shadow copy changes with it, while the block is idle.
	task automatic write_reg(logic [1:0] idx, logic [30:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tlbdl_pkg::CFG_DEFAULT_DELAY: cur_default = value;
			tlbdl_pkg::CFG_SEQ_MODE:      cur_seq_mode = value[1:0];
			default:                      cur_calc_mode = value[0];
		endcase
		@(posedge clk);
	endtask

	// Random request: mostly a narrow key space so groups fill and lookups hit.
	task automatic queue_random();
		logic [31:0] s, c, d;
		logic kind;
		kind = ($urandom_range(0, 9) < 4) ? tlbdl_pkg::REQ_INSERT : tlbdl_pkg::REQ_LOOKUP;
		s = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 10)) - 32'd5 : $urandom;
		case ($urandom_range(0, 9))
			0:       c = $urandom;
			1:       c = {1'b0, 31'($urandom)};
			default: c = $urandom_range(0, 40);
		endcase
		d = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1000000) : $urandom;
		queue_req(kind, s, c, d);
	endtask

	int unsigned fill_base;
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset settings.
		queue_req(tlbdl_pkg::REQ_LOOKUP, 0, 0, 0);                          // empty table
		queue_req(tlbdl_pkg::REQ_INSERT, 1, 32'hFFFF_FFFF, 5);              // negative offset
		queue_req(tlbdl_pkg::REQ_INSERT, 1, 5, 32'h8000_0000);              // negative delay
		queue_req(tlbdl_pkg::REQ_INSERT, 0, 0, 0);
		queue_req(tlbdl_pkg::REQ_INSERT, 0, 5, 100);
		queue_req(tlbdl_pkg::REQ_INSERT, 0, 5, 200);                        // repeated key
		queue_req(tlbdl_pkg::REQ_INSERT, 32'h8000_0000, 0, 32'h7FFF_FFFF);
		queue_req(tlbdl_pkg::REQ_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_req(tlbdl_pkg::REQ_INSERT, 3, 10, 7);
		queue_req(tlbdl_pkg::REQ_INSERT, 3, 20, 8);
		queue_req(tlbdl_pkg::REQ_LOOKUP, 0, 5, 0);
		queue_req(tlbdl_pkg::REQ_LOOKUP, 0, 6, 0);                          // past group end
		queue_req(tlbdl_pkg::REQ_LOOKUP, 2, 0, 0);                          // missing group
		queue_req(tlbdl_pkg::REQ_LOOKUP, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
		queue_req(tlbdl_pkg::REQ_LOOKUP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		queue_req(tlbdl_pkg::REQ_LOOKUP, 3, 15, 0);
		wait_idle();
		write_reg(tlbdl_pkg::CFG_SEQ_MODE, 31'(tlbdl_pkg::SEQ_GE));
		write_reg(tlbdl_pkg::CFG_CALC_MODE, 31'd1);
		write_reg(tlbdl_pkg::CFG_DEFAULT_DELAY, 31'h7FFF_FFFF);
		queue_req(tlbdl_pkg::REQ_LOOKUP, 1, 10, 0);
		queue_req(tlbdl_pkg::REQ_LOOKUP, 3, 20, 0);
		queue_req(tlbdl_pkg::REQ_LOOKUP, 32'h7FFF_FFFF, 0, 0);
		wait_idle();
		write_reg(tlbdl_pkg::CFG_SEQ_MODE, 31'(tlbdl_pkg::SEQ_GT));
		write_reg(tlbdl_pkg::CFG_DEFAULT_DELAY, '0);
		queue_req(tlbdl_pkg::REQ_LOOKUP, 0, 0, 0);
		queue_req(tlbdl_pkg::REQ_LOOKUP, 32'h7FFF_FFFF, 0, 0);
		wait_idle();
		write_reg(tlbdl_pkg::CFG_SEQ_MODE, 31'(SEQ_NONE));
		queue_req(tlbdl_pkg::REQ_LOOKUP, 0, 0, 0);
		wait_idle();

		// Random part, one setting per phase, the extremes among them.
		for (int phase = 0; phase < 10; phase++) begin
			write_reg(tlbdl_pkg::CFG_SEQ_MODE,
				(phase < 8) ? 31'(phase % 3) : 31'($urandom_range(0, 3)));
			write_reg(tlbdl_pkg::CFG_CALC_MODE, 31'((phase / 3) % 2));
			write_reg(tlbdl_pkg::CFG_DEFAULT_DELAY, (phase == 4) ? 31'h7FFF_FFFF :
				(phase == 5) ? 31'd0 : 31'($urandom));
			repeat (170) queue_random();
			if (phase == 6) begin
				// Hold the sender until the block has drained completely.
				while (pending_reqs.size() > 80) @(posedge clk);
				hold_sender = 1'b1;
				while (expected_rsps.size() > 0) @(posedge clk);
				repeat (20) @(posedge clk);
				hold_sender = 1'b0;
			end
			wait_idle();
		end

		// Fill the table with rising keys, then overflow it; only entries with larger
		// random keys move.
		write_reg(tlbdl_pkg::CFG_SEQ_MODE, 31'(tlbdl_pkg::SEQ_EXACT));
		write_reg(tlbdl_pkg::CFG_CALC_MODE, 31'd0);
		fill_base = shadow_count;
		for (int unsigned i = 0; i < TABLE_DEPTH - fill_base + 3; i++)
			queue_req(tlbdl_pkg::REQ_INSERT, 32'd1000 + i, i, i + 1);
		queue_req(tlbdl_pkg::REQ_INSERT, 32'd1000, 0, 9);                   // repeated key when full
		queue_req(tlbdl_pkg::REQ_INSERT, 0, 7, 9);                          // new key when full
		queue_req(tlbdl_pkg::REQ_LOOKUP, 32'd1000, 0, 0);
		queue_req(tlbdl_pkg::REQ_LOOKUP, 32'd1005, 0, 0);
		repeat (40) queue_random();
		wait_idle();

		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
